// ----- rtl/core/rlt_pkg.sv -----
// Package: shared types and constants of the range lock table.
`default_nettype none
package rlt_pkg;
  localparam int unsigned Entries = 32;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned KeyW = 64;

  localparam logic ActLock    = 1'b0;
  localparam logic ActRelease = 1'b1;

  localparam logic [2:0] StGranted  = 3'd0;
  localparam logic [2:0] StConflict = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StReleased = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StBadRange = 3'd5;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] range_start;
    logic [KeyW-1:0] range_end;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] held_count;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic            action;
    logic            bad;
    logic [KeyW-1:0] lo;
    logic [KeyW-1:0] hi;
  } cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/rlt_front.sv -----
// Front end: accept a request, check its range, and hand it to the back end.
`default_nettype none
module rlt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire rlt_pkg::req_t req_i,
  output logic               busy,
  output logic               cmd_valid_o,
  output rlt_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i,
  input  wire logic          back_idle_i
);
  logic          full_q, full_d;
  rlt_pkg::cmd_t cmd_q;

  // One item in flight: hold off new words until the back finishes.
  assign busy        = full_q | ~back_idle_i;
  assign cmd_valid_o = full_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    full_d = full_q;
    if (full_q && cmd_ready_i) full_d = 1'b0;
    if (start && !busy) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q.action <= req_i.action;
      cmd_q.bad    <= (&req_i.range_end) | (req_i.range_start > req_i.range_end);
      cmd_q.lo     <= req_i.range_start;
      cmd_q.hi     <= req_i.range_end;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/rlt_back.sv -----
// Back end: scan the table one entry a cycle and apply lock or release.
`default_nettype none
module rlt_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire rlt_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  output logic               idle_o,
  output logic               done_o,
  output rlt_pkg::rsp_t      rsp_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [rlt_pkg::Entries-1:0] valid_q;
  logic [rlt_pkg::KeyW-1:0]  first_mem [rlt_pkg::Entries];
  logic [rlt_pkg::KeyW-1:0]  last_mem  [rlt_pkg::Entries];
  logic [rlt_pkg::IdxW-1:0]  idx_q;
  logic [rlt_pkg::IdxW-1:0]  free_q;
  logic                      free_ok_q;
  logic [5:0]                held_q;
  rlt_pkg::cmd_t             cmd_q;
  logic [2:0]                st_q;
  logic                      done_q;
  logic [rlt_pkg::KeyW-1:0]  rd_first_q, rd_last_q;
  logic [rlt_pkg::IdxW-1:0]  rd_addr;
  logic                      hit, last_idx;

  // Read one entry ahead: entry 0 while waiting, the next entry while scanning.
  assign rd_addr     = (state_q == S_SCAN) ? idx_q + rlt_pkg::IdxW'(1) : '0;
  assign last_idx    = (idx_q == rlt_pkg::IdxW'(rlt_pkg::Entries - 1));
  assign cmd_ready_o = (state_q == S_IDLE);
  assign idle_o      = (state_q == S_IDLE) & ~cmd_valid_i;
  assign done_o      = done_q;
  assign rsp_o.status     = st_q;
  assign rsp_o.held_count = held_q;

  always_comb begin
    if (cmd_q.action == rlt_pkg::ActLock)
      hit = valid_q[idx_q] && (cmd_q.lo <= rd_last_q) && (rd_first_q <= cmd_q.hi);
    else
      hit = valid_q[idx_q] && (rd_first_q == cmd_q.lo);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i) state_d = cmd_i.bad && cmd_i.action == rlt_pkg::ActLock
                                         ? S_DONE : S_SCAN;
      S_SCAN: if (hit || last_idx) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      held_q    <= '0;
      idx_q     <= '0;
      free_q    <= '0;
      free_ok_q <= 1'b0;
      done_q    <= 1'b0;
      cmd_q     <= '0;
      st_q      <= rlt_pkg::StGranted;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          idx_q     <= '0;
          free_ok_q <= 1'b0;
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            st_q  <= rlt_pkg::StBadRange;
          end
        end
        S_SCAN: begin
          // Remember the lowest free slot while scanning.
          if (!valid_q[idx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_q    <= idx_q;
          end
          if (cmd_q.action == rlt_pkg::ActLock) begin
            if (hit) st_q <= rlt_pkg::StConflict;
            else if (last_idx) begin
              if (free_ok_q || !valid_q[idx_q]) begin
                st_q    <= rlt_pkg::StGranted;
                held_q  <= held_q + 6'd1;
                valid_q[free_ok_q ? free_q : idx_q] <= 1'b1;
              end else st_q <= rlt_pkg::StFull;
            end
          end else begin
            if (hit) begin
              st_q           <= rlt_pkg::StReleased;
              valid_q[idx_q] <= 1'b0;
              held_q         <= held_q - 6'd1;
            end else if (last_idx) st_q <= rlt_pkg::StNotFound;
          end
          idx_q <= idx_q + rlt_pkg::IdxW'(1);
        end
        S_DONE: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q <= first_mem[rd_addr];
    rd_last_q  <= last_mem[rd_addr];
    if (state_q == S_SCAN && cmd_q.action == rlt_pkg::ActLock && !hit && last_idx
        && (free_ok_q || !valid_q[idx_q])) begin
      first_mem[free_ok_q ? free_q : idx_q] <= cmd_q.lo;
      last_mem[free_ok_q ? free_q : idx_q]  <= cmd_q.hi;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/range_lock_table_unit.sv -----
// Top level of the range lock table: front, command register, back.
//
//  channel | signals              | handshake
//  --------+----------------------+-------------------------------
//  request | start, req_i         | taken when start & !busy
//  result  | done_o, rsp_o        | one-cycle strobe, no stall
//
// A word taken by the front end is registered there and then passed to the
// back end, which reads one table entry a cycle through a registered read
// port. The result strobe follows the scan of the last entry at the latest;
// a conflict or a matching release stops at its entry, and a lock with a bad
// range skips the scan. busy stays high until the strobe cycle. Reset empties
// the table at once; the receiver cannot stall.
`default_nettype none
module range_lock_table_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire rlt_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output rlt_pkg::rsp_t      rsp_o
);
  logic          cmd_valid, cmd_ready, back_idle;
  rlt_pkg::cmd_t cmd;

  rlt_front u_front (
    .clk_i, .rst_ni, .start, .req_i, .busy,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready),
    .back_idle_i(back_idle)
  );

  rlt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_ready_o(cmd_ready), .idle_o(back_idle), .done_o, .rsp_o
  );
endmodule
`default_nettype wire

// ----- bench/rlt_checker.sv -----
// Checker: watches request and result words, predicts the table, compares.
module rlt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  rlt_pkg::req_t req_i,
  input  logic          done,
  input  rlt_pkg::rsp_t rsp_o,
  output int            fail_count,
  output int            pending_count
);
  import rlt_pkg::*;

  logic            held_valid [Entries];
  logic [KeyW-1:0] held_first [Entries];
  logic [KeyW-1:0] held_last  [Entries];
  logic [5:0]      held_num;
  rsp_t            expected_rsp_q [$];

  task automatic report(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  // Apply one request word to the predicted table, return its result word.
  function automatic rsp_t apply_request(input req_t rq);
    rsp_t r;
    int   slot;
    bit   hit;
    slot = -1;
    hit  = 0;
    if (rq.action == ActLock) begin
      if (rq.range_end == '1 || rq.range_start > rq.range_end) begin
        r.status = StBadRange;
      end else begin
        for (int i = 0; i < Entries; i++) begin
          if (held_valid[i]) begin
            if (rq.range_start <= held_last[i] && held_first[i] <= rq.range_end) hit = 1;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (hit) r.status = StConflict;
        else if (slot < 0) r.status = StFull;
        else begin
          held_valid[slot] = 1;
          held_first[slot] = rq.range_start;
          held_last[slot]  = rq.range_end;
          held_num++;
          r.status = StGranted;
        end
      end
    end else begin
      r.status = StNotFound;
      for (int i = 0; i < Entries; i++) begin
        if (!hit && held_valid[i] && held_first[i] == rq.range_start) begin
          held_valid[i] = 0;
          held_num--;
          hit = 1;
          r.status = StReleased;
        end
      end
    end
    r.held_count = held_num;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    held_num = 0;
    for (int i = 0; i < Entries; i++) held_valid[i] = 0;
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = expected_rsp_q.pop_front();
          if (rsp_o.status !== e.status)
            report($sformatf("status got %0d want %0d", rsp_o.status, e.status));
          if (rsp_o.held_count !== e.held_count)
            report($sformatf("held_count got %0d want %0d", rsp_o.held_count, e.held_count));
        end
      end
      if (start && !busy) expected_rsp_q.push_back(apply_request(req_i));
    end
    pending_count <= expected_rsp_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives request words into the range lock table and gives the verdict.
module tb_top;
  import rlt_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  start = 0;
  req_t  req_i = '0;
  logic  busy, done;
  rsp_t  rsp_o;
  int    fail_count, pending_count;
  int    cycle_count = 0;

  // Keys come from a small pool so locks collide and releases find matches.
  logic [KeyW-1:0] key_pool [16];

  range_lock_table_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done), .rsp_o(rsp_o)
  );

  rlt_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done(done), .rsp_o(rsp_o), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #2 clk_i = ~clk_i;

  // End the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Present one word, hold it until taken, then, if gaps are allowed, now and then drop start.
  task automatic send_word(input logic act, input logic [KeyW-1:0] lo,
                           input logic [KeyW-1:0] hi, input bit allow_gap);
    start <= 1'b1;
    req_i <= '{action: act, range_start: lo, range_end: hi};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Insert an idle burst now and then; otherwise keep start high for the next word.
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      req_i <= '{action: 1'($urandom_range(0, 1)), range_start: rand_key(),
                 range_end: rand_key()};
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic random_word(input bit allow_gap);
    logic [KeyW-1:0] lo, hi;
    int              sel;
    sel = $urandom_range(0, 9);
    lo = key_pool[$urandom_range(0, 15)] + 64'($urandom_range(0, 40));
    hi = lo + 64'($urandom_range(0, 60));
    if (sel < 5) begin
      send_word(ActLock, lo, hi, allow_gap);
    end else if (sel < 8) begin
      // Release the exact start of a likely held range, sometimes off by one.
      send_word(ActRelease, lo - 64'($urandom_range(0, 3) == 0), rand_key(), allow_gap);
    end else if (sel == 8) begin
      send_word(ActLock, rand_key(), rand_key(), allow_gap);
    end else begin
      send_word(1'($urandom_range(0, 1)), rand_key(), '1, allow_gap);
    end
  endtask

  initial begin
    int drain;
    for (int i = 0; i < 16; i++) key_pool[i] = (i == 0) ? '0 : (rand_key() & ~64'hFFFF) ;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, bad ranges, overlaps, inexact release.
    send_word(ActLock, '0, '0, 0);
    send_word(ActLock, '0, 64'd5, 0);
    send_word(ActLock, 64'd10, 64'd9, 0);
    send_word(ActLock, 64'd10, '1, 0);
    send_word(ActLock, '1, '1, 0);
    send_word(ActLock, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    send_word(ActLock, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    send_word(ActLock, 64'd1, 64'd1, 0);
    send_word(ActRelease, 64'd1, '1, 0);
    send_word(ActRelease, 64'hFFFF_FFFF_FFFF_FFF1, '0, 0);
    send_word(ActRelease, 64'hFFFF_FFFF_FFFF_FFF0, '0, 0);
    send_word(ActRelease, '0, '0, 0);
    send_word(ActRelease, '0, '0, 0);
    // Fill the table, hit the full case, then empty it.
    for (int i = 0; i < 34; i++) send_word(ActLock, 64'd100 * i, 64'd100 * i + 50, 0);
    send_word(ActLock, 64'd100 * 40, 64'd100 * 40, 0);
    for (int i = 0; i < 32; i++) send_word(ActRelease, 64'd100 * i, '0, 0);

    // Random phase with idle bursts, then a tail with none.
    for (int n = 0; n < 360; n++) random_word(1);
    for (int n = 0; n < 60; n++) random_word(0);
    start <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 3 * 34) begin
      @(posedge clk_i);
      drain++;
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
